### sv/trimmed_mean_peak_normalizer_unit_macros.svh
// Assertion macros shared by the trimmed-mean normalizer RTL
`ifndef TRIMMED_MEAN_PEAK_NORMALIZER_UNIT_MACROS_SVH
`define TRIMMED_MEAN_PEAK_NORMALIZER_UNIT_MACROS_SVH

// implication checked every clock, masked during reset
`define TMPN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tmpn_pkg.sv
// Shared types and constants for the trimmed-mean peak normalizer
package tmpn_pkg;

  localparam int unsigned NumChannels  = 5;
  localparam int unsigned SampleBits   = 12;
  localparam int unsigned InitialPeak  = 3000;
  localparam int unsigned WindowLen    = 7;
  localparam int unsigned TrimKeep     = 5;
  localparam int unsigned FullScale    = 25600;
  localparam int unsigned PeakMin      = 5;
  localparam int unsigned OpW          = 2;
  localparam int unsigned ChW          = 3;
  localparam int unsigned InSampleW    = 12;
  localparam int unsigned ValW         = 15;
  localparam int unsigned FillW        = 3;

  localparam logic [OpW-1:0] OP_FILTER    = 2'd0;
  localparam logic [OpW-1:0] OP_DIRECT    = 2'd1;
  localparam logic [OpW-1:0] OP_CALIBRATE = 2'd2;

  typedef enum logic [1:0] {
    CMD_WINDOW = 2'd0,
    CMD_DIRECT = 2'd1,
    CMD_CALIB  = 2'd2,
    CMD_FILL   = 2'd3
  } cmd_e;

  // classified command passed from the front end to the back end
  typedef struct packed {
    cmd_e             cmd;
    logic [ChW-1:0]   channel;
    logic [FillW-1:0] slot;
    logic [15:0]      sample;
  } cmd_t;

endpackage

### sv/tmpn_front.sv
// Front end: input handshake, channel/opcode check, window slot tracking, command queue
`include "trimmed_mean_peak_normalizer_unit_macros.svh"
module tmpn_front #(
  parameter int unsigned NUM_CHANNELS = tmpn_pkg::NumChannels,
  parameter int unsigned SAMPLE_BITS  = tmpn_pkg::SampleBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tmpn_pkg::OpW-1:0]        operation_i,
  input  logic [tmpn_pkg::ChW-1:0]        channel_i,
  input  logic [tmpn_pkg::InSampleW-1:0]  sample_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output tmpn_pkg::cmd_t                  cmd_o
);

  localparam int unsigned Depth = 2;

  logic [tmpn_pkg::FillW-1:0] fill_q [NUM_CHANNELS];
  tmpn_pkg::cmd_t             fifo_q [Depth];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 count_q;
  logic                       accept, push, pop, ch_ok;
  tmpn_pkg::cmd_t             cmd_d;
  logic [tmpn_pkg::ChW-1:0]   ch_idx;

  assign in_ready = (count_q != 2'd2);
  assign accept   = in_valid && in_ready;
  assign ch_ok    = ({29'd0, channel_i} < NUM_CHANNELS);
  assign ch_idx   = ch_ok ? channel_i : '0;

  always_comb begin
    cmd_d.channel = channel_i;
    cmd_d.slot    = fill_q[ch_idx];
    cmd_d.sample  = 16'({4'd0, sample_i} & 16'((17'd1 << SAMPLE_BITS) - 17'd1));
    cmd_d.cmd     = tmpn_pkg::CMD_DIRECT;
    push          = 1'b0;
    if (ch_ok) begin
      case (operation_i)
        tmpn_pkg::OP_FILTER: begin
          push      = 1'b1;
          cmd_d.cmd = (fill_q[ch_idx] == 3'(tmpn_pkg::WindowLen - 1)) ?
                      tmpn_pkg::CMD_WINDOW : tmpn_pkg::CMD_FILL;
        end
        tmpn_pkg::OP_DIRECT: begin
          push      = 1'b1;
          cmd_d.cmd = tmpn_pkg::CMD_DIRECT;
        end
        tmpn_pkg::OP_CALIBRATE: begin
          push      = 1'b1;
          cmd_d.cmd = tmpn_pkg::CMD_CALIB;
        end
        default: push = 1'b0;
      endcase
    end
  end

  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) fill_q[i] <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (accept && push) begin
        fifo_q[wr_ptr_q] <= cmd_d;
        wr_ptr_q         <= ~wr_ptr_q;
        if (operation_i == tmpn_pkg::OP_FILTER) begin
          fill_q[ch_idx] <= (cmd_d.cmd == tmpn_pkg::CMD_WINDOW) ? '0 : fill_q[ch_idx] + 3'd1;
        end
      end
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, accept && push} - {1'b0, pop};
    end
  end

  `TMPN_ASSERT(a_no_overflow, accept && push && !pop, count_q < 2'd2, "queue overflow")
  `TMPN_ASSERT(a_no_underflow, pop, count_q != 2'd0, "queue underflow")
  `TMPN_ASSERT(a_fill_range, 1'b1, fill_q[0] < 3'(tmpn_pkg::WindowLen), "fill out of range")

endmodule

### sv/tmpn_back.sv
// Back end: window memory, serial min/max/sum, peak update, serial divider, output register
`include "trimmed_mean_peak_normalizer_unit_macros.svh"
module tmpn_back #(
  parameter int unsigned NUM_CHANNELS = tmpn_pkg::NumChannels,
  parameter int unsigned INITIAL_PEAK = tmpn_pkg::InitialPeak
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  tmpn_pkg::cmd_t              cmd_i,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmpn_pkg::ChW-1:0]    out_channel_o,
  output logic [tmpn_pkg::ValW-1:0]   level_o,
  output logic [tmpn_pkg::ValW-1:0]   percent_o,
  output logic [tmpn_pkg::ValW-1:0]   peak_now_o
);

  localparam int unsigned MemDepth = NUM_CHANNELS * tmpn_pkg::WindowLen;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned NumW     = 30;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_ACC, S_PEAK, S_DIV, S_OUT
  } state_e;

  logic [15:0]                mem_q [MemDepth];
  logic [15:0]                rd_q;
  state_e                     state_q;
  logic [tmpn_pkg::ValW-1:0]  peak_q [NUM_CHANNELS];
  logic [tmpn_pkg::ChW-1:0]   ch_q;
  logic [2:0]                 idx_q;
  logic [15:0]                lo_q, hi_q;
  logic [18:0]                sum_q;
  logic [tmpn_pkg::ValW-1:0]  level_q, pk_q;
  logic [NumW-1:0]            num_q;
  logic [NumW-1:0]            quo_q;
  logic [tmpn_pkg::ValW:0]    rem_q;
  logic [4:0]                 bit_q;
  logic [AddrW-1:0]           base;
  logic [tmpn_pkg::ValW-1:0]  s5;
  logic [tmpn_pkg::ValW:0]    rem_sh;
  logic                       take;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign base        = AddrW'({29'd0, cmd_i.channel} * tmpn_pkg::WindowLen);
  assign s5          = tmpn_pkg::ValW'({3'd0, cmd_i.sample} * 19'd5);
  assign rem_sh      = {rem_q[tmpn_pkg::ValW-1:0], num_q[NumW-1]};
  assign out_valid   = (state_q == S_OUT);

  // memory port: one write on any window command, one read per step in S_READ/S_ACC
  always_ff @(posedge clk_i) begin
    if (take && (cmd_i.cmd == tmpn_pkg::CMD_FILL || cmd_i.cmd == tmpn_pkg::CMD_WINDOW)) begin
      mem_q[base + AddrW'(cmd_i.slot)] <= cmd_i.sample;
    end
    rd_q <= mem_q[AddrW'({29'd0, ch_q} * tmpn_pkg::WindowLen) + AddrW'(idx_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        peak_q[i] <= tmpn_pkg::ValW'(INITIAL_PEAK * tmpn_pkg::TrimKeep);
      end
      ch_q  <= '0;
      idx_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (take) begin
          ch_q  <= cmd_i.channel;
          idx_q <= '0;
          case (cmd_i.cmd)
            tmpn_pkg::CMD_DIRECT: if (s5 > peak_q[cmd_i.channel]) peak_q[cmd_i.channel] <= s5;
            tmpn_pkg::CMD_CALIB:
              peak_q[cmd_i.channel] <= (cmd_i.sample == 16'd0) ? 15'd5 : s5;
            tmpn_pkg::CMD_WINDOW: state_q <= S_READ;
            default: ;
          endcase
        end
        S_READ: begin
          // rd_q valid next cycle; memory write of slot 6 already landed
          idx_q   <= idx_q + 3'd1;
          sum_q   <= '0;
          lo_q    <= 16'hFFFF;
          hi_q    <= '0;
          state_q <= S_ACC;
        end
        S_ACC: begin
          sum_q <= sum_q + {3'd0, rd_q};
          if (rd_q < lo_q) lo_q <= rd_q;
          if (rd_q > hi_q) hi_q <= rd_q;
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'(tmpn_pkg::WindowLen)) state_q <= S_PEAK;
        end
        S_PEAK: begin
          level_q <= tmpn_pkg::ValW'(sum_q - {3'd0, lo_q} - {3'd0, hi_q});
          if (tmpn_pkg::ValW'(sum_q - {3'd0, lo_q} - {3'd0, hi_q}) > peak_q[ch_q]) begin
            peak_q[ch_q] <= tmpn_pkg::ValW'(sum_q - {3'd0, lo_q} - {3'd0, hi_q});
            pk_q <= tmpn_pkg::ValW'(sum_q - {3'd0, lo_q} - {3'd0, hi_q});
          end else begin
            pk_q <= peak_q[ch_q];
          end
          num_q   <= NumW'(tmpn_pkg::ValW'(sum_q - {3'd0, lo_q} - {3'd0, hi_q})) *
                     NumW'(tmpn_pkg::FullScale);
          rem_q   <= '0;
          quo_q   <= '0;
          bit_q   <= 5'(NumW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem_sh >= {1'b0, pk_q}) begin
            rem_q <= rem_sh - {1'b0, pk_q};
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          num_q <= {num_q[NumW-2:0], 1'b0};
          bit_q <= bit_q - 5'd1;
          if (bit_q == 5'd1) state_q <= S_OUT;
        end
        S_OUT: if (out_ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_channel_o = ch_q;
  assign level_o       = level_q;
  assign peak_now_o    = pk_q;
  assign percent_o     = (pk_q < 15'(tmpn_pkg::PeakMin)) ? '0 :
                         (quo_q > NumW'(tmpn_pkg::FullScale)) ? 15'(tmpn_pkg::FullScale) :
                         quo_q[tmpn_pkg::ValW-1:0];

  `TMPN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, state_q == S_OUT, "out lost")
  `TMPN_ASSERT_NEXT(a_div_enter, state_q == S_PEAK, state_q == S_DIV, "divider not started")
  `TMPN_ASSERT(a_level_le_peak, out_valid, level_q <= pk_q, "level above peak")

endmodule

### sv/trimmed_mean_peak_normalizer_unit.sv
// Top level of the trimmed-mean peak normalizer
// Usage: items enter on in_valid/in_ready with operation_i, channel_i and
// sample_i. Filtered samples go into the channel's seven-slot window; the
// seventh one produces one result transaction on out_valid/out_ready with
// the channel, trimmed level, percent of peak and updated peak. Direct and
// calibrate operations only touch the peak and produce no transaction;
// out-of-range channels and operation code 3 are dropped.
// A two-entry command queue separates the front end from the back end.
// Peak updates and non-final window samples retire in the back-end idle
// state. A window completion runs serial memory reads for min/max/sum, a
// peak update and a restoring division, then the output register. Input
// stays open while the queue has room.
// Reset clears window fill counts and loads every peak with 5*INITIAL_PEAK;
// window memory contents are undefined until written.
// If the receiver stalls, the result holds and the back end stops; the front
// end keeps accepting until its queue is full.
module trimmed_mean_peak_normalizer_unit #(
  parameter int unsigned NUM_CHANNELS = tmpn_pkg::NumChannels,
  parameter int unsigned SAMPLE_BITS  = tmpn_pkg::SampleBits,
  parameter int unsigned INITIAL_PEAK = tmpn_pkg::InitialPeak
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tmpn_pkg::OpW-1:0]        operation_i,
  input  logic [tmpn_pkg::ChW-1:0]        channel_i,
  input  logic [tmpn_pkg::InSampleW-1:0]  sample_i,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tmpn_pkg::ChW-1:0]        out_channel_o,
  output logic [tmpn_pkg::ValW-1:0]       level_o,
  output logic [tmpn_pkg::ValW-1:0]       percent_o,
  output logic [tmpn_pkg::ValW-1:0]       peak_now_o
);

  logic           cmd_valid, cmd_ready;
  tmpn_pkg::cmd_t cmd;

  tmpn_front #(.NUM_CHANNELS(NUM_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .operation_i, .channel_i, .sample_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tmpn_back #(.NUM_CHANNELS(NUM_CHANNELS), .INITIAL_PEAK(INITIAL_PEAK)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid, .out_ready, .out_channel_o, .level_o, .percent_o, .peak_now_o
  );

endmodule
